[src/detection_dedup_cache_assert.svh]
// Assertion helpers for the cache RTL, used by its top module.
// All checks are sampled on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef DETECTION_DEDUP_CACHE_ASSERT_SVH
`define DETECTION_DEDUP_CACHE_ASSERT_SVH

// Same-cycle implication.
`define DDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ddc_pkg.sv]
package ddc_pkg;

    // Fixed geometry of the cache
    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = 5;
    localparam int CLASS_BITS = 8;
    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 32;

    // Configuration registers
    localparam int TTL_W  = 32;
    localparam int THR_W  = 9;
    localparam int CFG_W  = 32;
    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(1000);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

    typedef enum logic [0:0] {
        CFG_TTL = 1'b0,
        CFG_THR = 1'b1
    } t_cfg_reg;

    // Input mode codes
    localparam logic MODE_DETECT = 1'b0;
    localparam logic MODE_EXPIRE = 1'b1;

    // IoU arithmetic widths
    localparam int DIFF_W  = COORD_BITS + 1;           // signed coordinate difference
    localparam int AREA_W  = 2 * COORD_BITS + 1;       // signed box area
    localparam int INTER_W = 2 * COORD_BITS;           // unsigned intersection area
    localparam int UNI_W   = 2 * COORD_BITS + 3;       // signed union area
    localparam int MUL_W   = UNI_W + DIFF_W;           // shared multiplier product
    localparam int CMP_W   = UNI_W - 1 + THR_W;        // thr * positive union

    typedef struct packed {
        logic                  mode;
        logic [CLASS_BITS-1:0] class_id;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
        logic [TIME_BITS-1:0]  now_ticks;
    } t_in;

    typedef struct packed {
        logic             novel;
        logic [CNT_W-1:0] occupancy;
        logic             evicted_oldest;
    } t_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] left;
    } t_box;

    typedef struct packed {
        logic [CLASS_BITS-1:0] entry_class;
        t_box                  entry_box;
        logic [TIME_BITS-1:0]  entry_time;
    } t_entry;

    typedef enum logic [2:0] {
        OP_AREA_IN,
        OP_AREA_ENT,
        OP_INTER,
        OP_UNION,
        OP_SCALE
    } t_iou_op;

    typedef struct packed {
        logic    en;
        t_iou_op op;
    } t_iou_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREA,
        S_EXPIRE,
        S_AREA_B,
        S_INTER,
        S_UNION,
        S_SCALE,
        S_TEST,
        S_INSERT
    } t_state;

    // Ring index plus offset, wrapped to DEPTH
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-IDX_W){1'b0}}, base} + {1'b0, offs};
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[src/ddc_entry_mem.sv]
module ddc_entry_mem
    import ddc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ddc_iou_unit.sv]
module ddc_iou_unit
    import ddc_pkg::*;
(
    input  logic             i_clk,
    input  t_iou_ctl         i_ctl,
    input  t_box             i_box_in,
    input  t_box             i_box_ent,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_hit
);

    logic signed [UNI_W-1:0]   mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [MUL_W-1:0]   mul_p;
    logic signed [AREA_W-1:0]  r_area_a;
    logic signed [AREA_W-1:0]  r_area_b;
    logic        [INTER_W-1:0] r_inter;
    logic signed [UNI_W-1:0]   r_uni;
    logic        [CMP_W-1:0]   r_scaled;
    logic                      uni_pos;

    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_BITS-1:0] hi,
                                                      input logic [COORD_BITS-1:0] lo);
        return $signed({1'b0, hi}) - $signed({1'b0, lo});
    endfunction

    // overlap extent on one axis, clamped at zero
    function automatic logic signed [DIFF_W-1:0] extent(input logic [COORD_BITS-1:0] a0,
                                                        input logic [COORD_BITS-1:0] a1,
                                                        input logic [COORD_BITS-1:0] b0,
                                                        input logic [COORD_BITS-1:0] b1);
        logic [COORD_BITS-1:0]     hi;
        logic [COORD_BITS-1:0]     lo;
        logic signed [DIFF_W-1:0]  d;
        hi = (a1 < b1) ? a1 : b1;
        lo = (a0 > b0) ? a0 : b0;
        d  = diff(hi, lo);
        return d[DIFF_W-1] ? '0 : d;
    endfunction

    function automatic logic signed [UNI_W-1:0] sx(input logic signed [DIFF_W-1:0] d);
        return {{(UNI_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctl.op)
            OP_AREA_IN: begin
                mul_a = sx(diff(i_box_in.right, i_box_in.left));
                mul_b = diff(i_box_in.bottom, i_box_in.top);
            end
            OP_AREA_ENT: begin
                mul_a = sx(diff(i_box_ent.right, i_box_ent.left));
                mul_b = diff(i_box_ent.bottom, i_box_ent.top);
            end
            OP_INTER: begin
                mul_a = sx(extent(i_box_in.left, i_box_in.right,
                                  i_box_ent.left, i_box_ent.right));
                mul_b = extent(i_box_in.top, i_box_in.bottom,
                               i_box_ent.top, i_box_ent.bottom);
            end
            OP_SCALE: begin
                mul_a = r_uni;
                mul_b = $signed({{(DIFF_W-THR_W){1'b0}}, i_thr});
            end
            OP_UNION: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            unique case (i_ctl.op)
                OP_AREA_IN:  r_area_a <= mul_p[AREA_W-1:0];
                OP_AREA_ENT: r_area_b <= mul_p[AREA_W-1:0];
                OP_INTER:    r_inter  <= mul_p[INTER_W-1:0];
                OP_UNION: begin
                    r_uni <= {{(UNI_W-AREA_W){r_area_a[AREA_W-1]}}, r_area_a}
                           + {{(UNI_W-AREA_W){r_area_b[AREA_W-1]}}, r_area_b}
                           - $signed({{(UNI_W-INTER_W){1'b0}}, r_inter});
                end
                OP_SCALE:    r_scaled <= mul_p[CMP_W-1:0];
            endcase
        end
    end

    // inter*256 >= thr*union; an empty or negative union only matches a zero threshold
    assign uni_pos = !r_uni[UNI_W-1] && (r_uni != '0);
    assign o_hit   = uni_pos ? ({{(CMP_W-INTER_W-8){1'b0}}, r_inter, 8'b0} >= r_scaled)
                             : (i_thr == '0);

endmodule

[src/detection_dedup_cache.sv]
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------------
// item in  | i_item                                  | taken when start high, busy low
// result   | o_result                                | o_result_valid, one cycle, no stall
// config   | i_cfg_we, i_cfg_index, i_cfg_data       | written on any edge with i_cfg_we out of reset
//
// Busy while an item is handled: area of the incoming box, expiry of stale entries, then a
// scan of the live entries with an IoU test per same-class entry and, if novel, the insert;
// a duplicate ends the scan early and expire mode stops after expiry. One shared multiplier
// (three uses per same-class entry) and one memory read port set the busy time.
// Reset (synchronous, active low) empties the ring and holds busy high; entries not cleared.
// The result beat appears in the cycle busy falls; the receiver cannot stall it.
module detection_dedup_cache
    import ddc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_item,
    output logic             o_result_valid,
    output t_out             o_result,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

`include "detection_dedup_cache_assert.svh"

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_out             r_out, n_out;
    logic             r_result_valid, n_result_valid;
    t_in              r_in;
    logic [TTL_W-1:0] r_ttl;
    logic [THR_W-1:0] r_thr;

    t_iou_ctl         iou_ctl;
    logic             iou_hit;
    t_box             box_in;
    t_entry           rd_entry;
    t_entry           wr_entry;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [TIME_BITS-1:0] age;
    logic             full;

    assign box_in = '{bottom: r_in.bottom, right: r_in.right, top: r_in.top, left: r_in.left};
    assign wr_entry = '{entry_class: r_in.class_id, entry_box: box_in,
                        entry_time: r_in.now_ticks};

    // wrapping age of the entry under the read port
    assign age  = r_in.now_ticks - rd_entry.entry_time;
    assign full = (r_count == CNT_W'(DEPTH));

    // read address follows the next pointer, so the data is there when the state needs it
    assign mem_raddr = idx_add(n_oldest, n_idx);
    assign mem_waddr = full ? r_oldest : idx_add(r_oldest, r_count);

    ddc_entry_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_entry),
        .i_raddr (mem_raddr),
        .o_rdata (rd_entry)
    );

    ddc_iou_unit u_iou (
        .i_clk     (i_clk),
        .i_ctl     (iou_ctl),
        .i_box_in  (box_in),
        .i_box_ent (rd_entry.entry_box),
        .i_thr     (r_thr),
        .o_hit     (iou_hit)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TTL: r_ttl <= i_cfg_data[TTL_W-1:0];
                CFG_THR: r_thr <= i_cfg_data[THR_W-1:0];
            endcase
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_oldest       <= '0;
            r_count        <= '0;
            r_idx          <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_oldest       <= n_oldest;
            r_count        <= n_count;
            r_idx          <= n_idx;
            r_result_valid <= n_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state        = r_state;
        n_oldest       = r_oldest;
        n_count        = r_count;
        n_idx          = r_idx;
        n_out          = r_out;
        n_result_valid = 1'b0;
        iou_ctl        = '{en: 1'b0, op: OP_AREA_IN};
        mem_we         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (start) begin
                    n_state = S_AREA;
                end
            end
            // area of the incoming box, once per item
            S_AREA: begin
                iou_ctl = '{en: 1'b1, op: OP_AREA_IN};
                n_state = S_EXPIRE;
            end
            // pop stale entries from the oldest end, one per cycle
            S_EXPIRE: begin
                if (r_count != '0 && age > r_ttl) begin
                    n_oldest = idx_add(r_oldest, CNT_W'(1));
                    n_count  = r_count - CNT_W'(1);
                end else if (r_in.mode == MODE_EXPIRE) begin
                    n_out          = '{novel: 1'b0, occupancy: r_count, evicted_oldest: 1'b0};
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_idx   = '0;
                    n_state = S_AREA_B;
                end
            end
            // scan: class filter, then stored box area
            S_AREA_B: begin
                if (r_idx == r_count) begin
                    n_state = S_INSERT;
                end else if (rd_entry.entry_class != r_in.class_id) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    iou_ctl = '{en: 1'b1, op: OP_AREA_ENT};
                    n_state = S_INTER;
                end
            end
            S_INTER: begin
                iou_ctl = '{en: 1'b1, op: OP_INTER};
                n_state = S_UNION;
            end
            S_UNION: begin
                iou_ctl = '{en: 1'b1, op: OP_UNION};
                n_state = S_SCALE;
            end
            S_SCALE: begin
                iou_ctl = '{en: 1'b1, op: OP_SCALE};
                n_state = S_TEST;
            end
            S_TEST: begin
                if (iou_hit) begin
                    // duplicate: nothing stored
                    n_out          = '{novel: 1'b0, occupancy: r_count, evicted_oldest: 1'b0};
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_AREA_B;
                end
            end
            // append; a full ring overwrites its oldest slot
            S_INSERT: begin
                mem_we = 1'b1;
                if (full) begin
                    n_oldest = idx_add(r_oldest, CNT_W'(1));
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                n_out          = '{novel: 1'b1, occupancy: n_count, evicted_oldest: full};
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
        endcase
    end

    // no item is taken while reset is held
    assign busy           = !i_rst_n || (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_out;

    `DDC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH),
        "entry count above depth")
    `DDC_ASSERT_NOW(a_evict_full, o_result_valid && o_result.evicted_oldest,
        o_result.novel && o_result.occupancy == CNT_W'(DEPTH),
        "eviction reported without a full store")
    `DDC_ASSERT_NOW(a_occ_track, o_result_valid, o_result.occupancy == r_count,
        "reported occupancy differs from ring count")
    `DDC_ASSERT_NEXT(a_take_busy, start && !busy, busy && !o_result_valid,
        "accepted item did not make the block busy")
    `DDC_ASSERT_NEXT(a_single_beat, o_result_valid, !o_result_valid,
        "result beat held for more than one cycle")

endmodule

[dv/tb_detection_dedup_cache.sv]
`timescale 1ns / 100ps

// Testbench for the detection de-duplication cache.
// A directed script runs first, then randomised phases under a range of TTL and IoU
// threshold settings. A shadow copy of the ring predicts every result beat not typed into the script.
module tb_detection_dedup_cache;
    import ddc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RAND_ITEMS    = 550;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 120;
    // No beat in either direction for this long means the block has hung.
    localparam int QUIET_LIMIT   = 2000;
    localparam int POOL_SIZE     = 24;
    localparam int SCRIPT_MAX    = 32;
    localparam int DUE_SLOTS     = 8;

    localparam t_out NO_VERDICT = '0;

    typedef struct {
        t_in  item;
        bit   pinned;   // expected beat typed into the script
        t_out want;
    } t_script_row;

    typedef struct {
        logic [TTL_W-1:0] ttl;
        logic [THR_W-1:0] thr;
        int unsigned      tick_step;
    } t_phase;

    // ---------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ---------------------------------------------------------------------
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_in              i_item      = '0;
    logic             o_result_valid;
    t_out             o_result;
    logic             i_cfg_we    = 1'b0;
    t_cfg_reg         i_cfg_index = CFG_TTL;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    detection_dedup_cache u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Shadow cache: oldest entry at shadow_head, shadow_count live entries
    // ---------------------------------------------------------------------
    logic [CLASS_BITS-1:0] shadow_class [DEPTH];
    t_box                  shadow_box   [DEPTH];
    logic [TIME_BITS-1:0]  shadow_time  [DEPTH];
    int                    shadow_head  = 0;
    int                    shadow_count = 0;
    logic [TTL_W-1:0]      shadow_ttl   = TTL_RESET;
    logic [THR_W-1:0]      shadow_thr   = THR_RESET;

    // expected beats, one per accepted item, oldest at due_rd
    t_out        verdicts_due [DUE_SLOTS];
    int          due_wr = 0;
    int          due_rd = 0;
    t_script_row script [SCRIPT_MAX];
    int          script_len = 0;
    // recent detections, seeds for near-duplicates
    t_in         recent [POOL_SIZE];
    int          recent_fill = 0;
    int          recent_next = 0;
    t_phase      phases [NUM_PHASES];

    logic [TIME_BITS-1:0] tick_now   = '0;
    int unsigned          tick_step  = 64;
    int                   burst_left = 1;
    int                   fault_count = 0;
    int                   quiet_cycles = 0;
    t_out                 due;

    // IoU >= thr/256 done exactly: inter*256 >= thr*union. Boxes may be inverted,
    // so areas stay signed and only the overlap extent is clamped at zero.
    function automatic bit iou_hits(input t_box a, input t_box b);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint iw, ih, inter, uni;
        ax0 = a.left;  ay0 = a.top;  ax1 = a.right;  ay1 = a.bottom;
        bx0 = b.left;  by0 = b.top;  bx1 = b.right;  by1 = b.bottom;
        iw = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
        ih = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni   = (ax1 - ax0) * (ay1 - ay0) + (bx1 - bx0) * (by1 - by0) - inter;
        // Degenerate union reads as IoU 0: only a zero threshold lets it through
        if (uni <= 0) return shadow_thr == '0;
        return inter * 256 >= longint'(shadow_thr) * uni;
    endfunction

    // Advances the shadow cache by one item and returns the beat it should cause
    function automatic t_out dedup_verdict(input t_in it);
        t_out verdict;
        t_box b;
        bit   dup;
        int   slot;
        int   i;
        verdict  = '0;
        b.left   = it.left;
        b.top    = it.top;
        b.right  = it.right;
        b.bottom = it.bottom;
        // Age is a wrapping difference, so a clock running backwards expires entries
        while (shadow_count != 0 && it.now_ticks - shadow_time[shadow_head] > shadow_ttl) begin
            shadow_head  = (shadow_head + 1) % DEPTH;
            shadow_count = shadow_count - 1;
        end
        if (it.mode == MODE_DETECT) begin
            dup = 1'b0;
            for (i = 0; i < shadow_count && !dup; i++) begin
                slot = (shadow_head + i) % DEPTH;
                if (shadow_class[slot] == it.class_id && iou_hits(shadow_box[slot], b)) begin
                    dup = 1'b1;
                end
            end
            if (!dup) begin
                if (shadow_count >= DEPTH) begin
                    // Ring full: overwrite the oldest live entry
                    slot        = shadow_head;
                    shadow_head = (shadow_head + 1) % DEPTH;
                    verdict.evicted_oldest = 1'b1;
                end else begin
                    slot         = (shadow_head + shadow_count) % DEPTH;
                    shadow_count = shadow_count + 1;
                end
                shadow_class[slot] = it.class_id;
                shadow_box[slot]   = b;
                shadow_time[slot]  = it.now_ticks;
                verdict.novel      = 1'b1;
            end
        end
        verdict.occupancy = CNT_W'(shadow_count);
        return verdict;
    endfunction

    function automatic t_in pack_item(input logic mode, input int cls,
                                      input int x0, input int y0, input int x1, input int y1,
                                      input logic [TIME_BITS-1:0] now);
        t_in it;
        it.mode      = mode;
        it.class_id  = CLASS_BITS'(cls);
        it.left      = COORD_BITS'(x0);
        it.top       = COORD_BITS'(y0);
        it.right     = COORD_BITS'(x1);
        it.bottom    = COORD_BITS'(y1);
        it.now_ticks = now;
        return it;
    endfunction

    function automatic t_out pack_verdict(input bit novel, input int occ, input bit evicted);
        t_out v;
        v.novel          = novel;
        v.occupancy      = CNT_W'(occ);
        v.evicted_oldest = evicted;
        return v;
    endfunction

    // Small jitter around a stored coordinate, clamped to the pixel range
    function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] c);
        int v;
        if ($urandom_range(0, 2) == 0) return c;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
        return COORD_BITS'(v);
    endfunction

    // Mostly near-duplicates of recent boxes and modest well-formed boxes of a few
    // classes, with the clock ticking forward; the rest is noise, jumps and rewinds.
    function automatic t_in draw_item();
        t_in it;
        t_in seed;
        int  r;
        r = $urandom_range(0, 99);
        if (r < 3)       tick_now = $urandom();
        else if (r < 7)  tick_now = tick_now - $urandom_range(1, 64);
        else if (r < 85) tick_now = tick_now + $urandom_range(0, tick_step);
        it.now_ticks = tick_now;
        it.mode      = ($urandom_range(0, 99) < 8) ? MODE_EXPIRE : MODE_DETECT;
        r = $urandom_range(0, 99);
        if (r < 55 && recent_fill != 0) begin
            seed        = recent[$urandom_range(0, recent_fill - 1)];
            it.class_id = seed.class_id;
            it.left     = nudge(seed.left);
            it.top      = nudge(seed.top);
            it.right    = nudge(seed.right);
            it.bottom   = nudge(seed.bottom);
        end else if (r < 80) begin
            it.class_id = CLASS_BITS'($urandom_range(0, 3));
            it.left     = COORD_BITS'($urandom_range(0, 3900));
            it.top      = COORD_BITS'($urandom_range(0, 3900));
            it.right    = it.left + COORD_BITS'($urandom_range(0, 195));
            it.bottom   = it.top + COORD_BITS'($urandom_range(0, 195));
        end else if (r < 86) begin
            // zero-area box
            it.class_id = CLASS_BITS'($urandom_range(0, 3));
            it.left     = COORD_BITS'($urandom());
            it.top      = COORD_BITS'($urandom());
            it.right    = it.left;
            it.bottom   = ($urandom_range(0, 1) == 0) ? it.top : COORD_BITS'($urandom());
        end else begin
            // raw noise, inverted boxes included
            it.class_id = CLASS_BITS'($urandom());
            it.left     = COORD_BITS'($urandom());
            it.top      = COORD_BITS'($urandom());
            it.right    = COORD_BITS'($urandom());
            it.bottom   = COORD_BITS'($urandom());
        end
        if (it.mode == MODE_DETECT) begin
            // pool keeps the last POOL_SIZE detections
            recent[recent_next] = it;
            recent_next = (recent_next + 1) % POOL_SIZE;
            if (recent_fill < POOL_SIZE) recent_fill = recent_fill + 1;
        end
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // Presents one item and waits for the edge that takes it (start high, busy low).
    // start is left high so a back-to-back item needs no second drive in this step.
    task automatic offer_item(input t_in it, input bit pinned, input t_out want);
        t_out predicted;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = dedup_verdict(it);
        verdicts_due[due_wr % DUE_SLOTS] = pinned ? want : predicted;
        due_wr = due_wr + 1;
    endtask

    // Bursts of random length with random gaps; now and then a long unbroken run
    task automatic pace_sender();
        int gap;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            gap = $urandom_range(0, 15);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops sending, waits for every expected beat, then lets the block settle
    task automatic drain(input int settle);
        start <= 1'b0;
        while (due_rd != due_wr) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Both registers written back to back while the block is idle
    task automatic program_config(input logic [TTL_W-1:0] ttl, input logic [THR_W-1:0] thr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TTL;
        i_cfg_data  <= CFG_W'(ttl);
        @(posedge i_clk);
        shadow_ttl   = ttl;
        i_cfg_index <= CFG_THR;
        // bits above the register width ride along and must be dropped
        i_cfg_data  <= {(CFG_W - THR_W)'($urandom()), thr};
        @(posedge i_clk);
        shadow_thr   = thr;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic add_row(input t_in it, input bit pinned, input t_out want);
        if (script_len < SCRIPT_MAX) begin
            script[script_len] = '{it, pinned, want};
            script_len = script_len + 1;
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        int i;
        int p;

        // Directed script under reset settings (TTL 1000, threshold 0.5)
        add_row(pack_item(MODE_EXPIRE, 0, 0, 0, 0, 0, 0), 1'b1, pack_verdict(0, 0, 0));
        add_row(pack_item(MODE_DETECT, 0, 0, 0, 100, 100, 10), 1'b1, pack_verdict(1, 1, 0));
        // identical box, same class: IoU 1.0
        add_row(pack_item(MODE_DETECT, 0, 0, 0, 100, 100, 20), 1'b1, pack_verdict(0, 1, 0));
        add_row(pack_item(MODE_DETECT, 255, 0, 0, 4095, 4095, 30), 1'b1, pack_verdict(1, 2, 0));
        // fully inverted box against the full-frame box of the same class
        add_row(pack_item(MODE_DETECT, 255, 4095, 4095, 0, 0, 40), 1'b0, NO_VERDICT);
        // zero-area boxes: the second one meets a zero union
        add_row(pack_item(MODE_DETECT, 9, 5, 5, 5, 5, 50), 1'b0, NO_VERDICT);
        add_row(pack_item(MODE_DETECT, 9, 5, 5, 5, 5, 60), 1'b0, NO_VERDICT);
        // shifted box, IoU about 0.82
        add_row(pack_item(MODE_DETECT, 0, 10, 0, 110, 100, 70), 1'b0, NO_VERDICT);
        // everything is well past TTL here
        add_row(pack_item(MODE_EXPIRE, 0, 0, 0, 0, 0, 2000), 1'b1, pack_verdict(0, 0, 0));
        for (i = 0; i < DEPTH; i++) begin
            add_row(pack_item(MODE_DETECT, i, i * 16, 0, i * 16 + 8, 8, 2000),
                    1'b1, pack_verdict(1, i + 1, 0));
        end
        // ring full: oldest overwritten
        add_row(pack_item(MODE_DETECT, 16, 300, 300, 310, 310, 2000), 1'b1, pack_verdict(1, 16, 1));
        // clock one tick backwards: ages wrap and everything expires
        add_row(pack_item(MODE_EXPIRE, 0, 0, 0, 0, 0, 1999), 1'b1, pack_verdict(0, 0, 0));

        // Random phases: extremes of both registers, a threshold above 1.0 and a few
        // ordinary settings. tick_step sets how fast entries age against the TTL.
        phases[0] = '{TTL_W'(1000), THR_W'(128), 64};
        phases[1] = '{TTL_W'(0), THR_W'(0), 2};
        phases[2] = '{{TTL_W{1'b1}}, THR_W'(256), 5000};
        phases[3] = '{TTL_W'(300), THR_W'(511), 40};
        phases[4] = '{TTL_W'(50), THR_W'(1), 8};
        phases[5] = '{TTL_W'(5000), THR_W'(200), 400};
        phases[6] = '{TTL_W'($urandom_range(0, 4000)), THR_W'($urandom_range(0, 256)), 100};
        phases[7] = '{TTL_W'(2000), THR_W'(255), 120};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < script_len; i++) begin
            offer_item(script[i].item, script[i].pinned, script[i].want);
            pace_sender();
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            drain(SETTLE_CYCLES);
            program_config(phases[p].ttl, phases[p].thr);
            tick_step   = phases[p].tick_step;
            tick_now    = $urandom();
            recent_fill = 0;
            recent_next = 0;
            for (i = 0; i < RAND_ITEMS / NUM_PHASES; i++) begin
                offer_item(draw_item(), 1'b0, NO_VERDICT);
                pace_sender();
            end
        end

        drain(TAIL_CYCLES);
        if (fault_count == 0) begin
            $display("detection_dedup_cache test passed");
        end else begin
            $display("detection_dedup_cache test failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Result checking and watchdog
    // Values read here are the pre-edge ones, as the DUT sees them.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (due_rd == due_wr) begin
                $display("%0t: unexpected result beat %p", $time, o_result);
                fault_count++;
            end else begin
                due    = verdicts_due[due_rd % DUE_SLOTS];
                due_rd = due_rd + 1;
                if (o_result.novel !== due.novel) begin
                    $display("%0t: novel expected %0b got %0b", $time, due.novel, o_result.novel);
                    fault_count++;
                end
                if (o_result.occupancy !== due.occupancy) begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $time, due.occupancy, o_result.occupancy);
                    fault_count++;
                end
                if (o_result.evicted_oldest !== due.evicted_oldest) begin
                    $display("%0t: evicted_oldest expected %0b got %0b",
                             $time, due.evicted_oldest, o_result.evicted_oldest);
                    fault_count++;
                end
            end
        end

        // any beat, in or out, counts as progress
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("detection_dedup_cache test failed");
            $finish;
        end
    end

endmodule
